### rtl/value_noise_2d_octaves_defines.svh
// Assertion macros of the value noise top level.
`ifndef VALUE_NOISE_2D_OCTAVES_DEFINES_SVH
`define VALUE_NOISE_2D_OCTAVES_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define VNO_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("value noise assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define VNO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("value noise assertion failed");

`endif

### rtl/vno_pkg.sv
// Types, constants and constant functions of the value noise pipeline.
`timescale 1ns / 1ps

package vno_pkg;

  localparam int COORD_W    = 24;
  localparam int PERS_W     = 16;
  localparam int OCTN_W     = 4;
  localparam int NOISE_W    = 32;
  localparam int LAT_W      = 32;
  localparam int WGT_W      = 17;
  localparam int V_W        = 22;
  localparam int AMP_W      = 42;
  localparam int AMP_LO_W   = 21;
  localparam int TERM_W     = 48;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 1'b1;

  localparam logic signed [PERS_W-1:0] PERS_RESET = 16'sd4096;
  localparam logic [OCTN_W-1:0]        OCTN_RESET = 4'd2;

  // Lattice hash constants.
  localparam logic [31:0] HASH_ROW  = 32'd57;
  localparam logic [31:0] HASH_MUL  = 32'd15731;
  localparam logic [31:0] HASH_ADD  = 32'd789221;
  localparam logic [31:0] HASH_OFS  = 32'd1376312589;
  localparam logic [31:0] HASH_MASK = 32'h7fff_ffff;
  localparam logic [31:0] LAT_ONE   = 32'h4000_0000;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  localparam logic signed [AMP_W-1:0] AMP_ONE   = 42'sd8192;
  localparam logic signed [AMP_W-1:0] AMP_LIMIT = 42'sd1099511627776;

  typedef logic [COORD_W-1:0]           coord_t;
  typedef logic signed [PERS_W-1:0]     pers_t;
  typedef logic [OCTN_W-1:0]            octn_t;
  typedef logic signed [NOISE_W-1:0]    noise_t;
  typedef logic signed [V_W-1:0]        oct_val_t;
  typedef logic signed [AMP_W-1:0]      amp_t;
  typedef logic [WGT_W-1:0]             wgt_t;
  typedef logic signed [LAT_W-1:0]      lat_t;
  typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]        cfg_data_t;

  // Lower half of the cosine weight table: sin^2 by a truncated series in Q30.
  function automatic longint unsigned weight_low(longint unsigned k, int bits);
    longint unsigned v, v2, t3, t2, t1, s;
    v  = (PI_Q30 * k) >> (bits + 1);
    v2 = (v * v) >> 30;
    t3 = ONE_Q30 - v2 / 64'd42;
    t2 = ONE_Q30 - ((v2 * t3) >> 30) / 64'd20;
    t1 = ONE_Q30 - ((v2 * t2) >> 30) / 64'd6;
    s  = (v * t1) >> 30;
    return (s * s + (64'd1 << 43)) >> 44;
  endfunction

  // Cosine interpolation weight in Q1.16; the upper half mirrors the lower.
  function automatic wgt_t cos_weight(int k, int bits);
    longint unsigned size, kk, w;
    size = 64'd1 << bits;
    kk = longint'(k) & (size - 64'd1);
    if (2 * kk > size) begin
      w = 64'd65536 - weight_low(size - kk, bits);
    end else begin
      w = weight_low(kk, bits);
    end
    return WGT_W'(w);
  endfunction

  // Hash offset of a point of the 4x4 lattice window, relative to its base.
  function automatic logic [31:0] pt_offset(logic [3:0] p);
    int dx, dy;
    dx = int'(p[1:0]) - 1;
    dy = int'(p[3:2]) - 1;
    return 32'(dx + 57 * dy);
  endfunction

  // Amplitude of an octave at the reset persistence of one half.
  function automatic amp_t amp_reset(int i);
    int a;
    a = 8192;
    for (int k = 0; k < i; k++) a = (a + 1) >>> 1;
    return AMP_W'(a);
  endfunction

endpackage

### rtl/vno_octave.sv
// One octave of value noise: hash, smoothing and cosine blend, 13 stages.
`timescale 1ns / 1ps

module vno_octave #(
  parameter int OCT            = 0,
  parameter int FRAC_BITS      = 12,
  parameter int COS_TABLE_BITS = 8
) (
  input  logic              clk,
  input  vno_pkg::coord_t   x_coord,
  input  vno_pkg::coord_t   y_coord,
  output vno_pkg::oct_val_t v
);
  import vno_pkg::*;

  localparam int SX_W    = COORD_W + OCT;
  localparam int TBL     = 1 << COS_TABLE_BITS;
  localparam int NPTS    = 16;

  localparam logic signed [WGT_W:0]      W_ONE = 18'sd65536;
  localparam logic signed [35:0]         RND4  = 36'sd8;
  localparam logic signed [49:0]         RND16 = 50'sd32768;
  localparam logic signed [LAT_W-1:0]    RND10 = 32'sd512;

  logic [SX_W-1:0]           sx, sy;
  logic [COS_TABLE_BITS-1:0] idx_x, idx_y;

  logic [31:0]               ix1, iy1, base2;
  logic [COS_TABLE_BITS-1:0] widx1, widy1;
  wgt_t                      rom [TBL];
  wgt_t                      wx_d [7];
  wgt_t                      wy_d [9];

  logic [31:0]  mix2 [NPTS];
  logic [31:0]  n3 [NPTS], n4 [NPTS], n5 [NPTS];
  logic [31:0]  sq4 [NPTS], t5 [NPTS];
  lat_t         lat6 [NPTS];
  logic signed [33:0] csum7 [4], ssum7 [4];
  lat_t         ctr7 [4];
  lat_t         sm8 [4];
  logic signed [49:0] pa9 [4];
  lat_t         tb10 [2];
  logic signed [49:0] pq11 [2];
  lat_t         o12;
  logic signed [WGT_W:0] wxc, wxi, wyc, wyi;

  // Scale by the octave and split into lattice integer and table index.
  assign sx = SX_W'(x_coord) << OCT;
  assign sy = SX_W'(y_coord) << OCT;

  if (FRAC_BITS >= COS_TABLE_BITS) begin : g_idx_cut
    assign idx_x = sx[FRAC_BITS-1 -: COS_TABLE_BITS];
    assign idx_y = sy[FRAC_BITS-1 -: COS_TABLE_BITS];
  end else begin : g_idx_pad
    assign idx_x = {sx[FRAC_BITS-1:0], {(COS_TABLE_BITS - FRAC_BITS){1'b0}}};
    assign idx_y = {sy[FRAC_BITS-1:0], {(COS_TABLE_BITS - FRAC_BITS){1'b0}}};
  end

  // Constant cosine weight table.
  for (genvar k = 0; k < TBL; k++) begin : g_rom
    localparam wgt_t ENTRY = cos_weight(k, COS_TABLE_BITS);
    assign rom[k] = ENTRY;
  end

  // Stages 1 and 2: lattice coordinates, hash base and weight lookup.
  always_ff @(posedge clk) begin
    ix1   <= 32'(sx >> FRAC_BITS);
    iy1   <= 32'(sy >> FRAC_BITS);
    widx1 <= idx_x;
    widy1 <= idx_y;
    base2   <= ix1 + iy1 * HASH_ROW;
    wx_d[0] <= rom[widx1];
    wy_d[0] <= rom[widy1];
    for (int s = 1; s < 7; s++) wx_d[s] <= wx_d[s-1];
    for (int s = 1; s < 9; s++) wy_d[s] <= wy_d[s-1];
  end

  // Shift and fold the hash input of each window point.
  always_comb begin
    for (int p = 0; p < NPTS; p++) begin
      mix2[p] = ((base2 + pt_offset(4'(p))) << 13) ^ (base2 + pt_offset(4'(p)));
    end
  end

  // Stages 3 to 6: the polynomial hash; stage 3 registers the input, each later one multiplies.
  always_ff @(posedge clk) begin
    for (int p = 0; p < NPTS; p++) begin
      n3[p]   <= mix2[p];
      sq4[p]  <= n3[p] * n3[p];
      n4[p]   <= n3[p];
      t5[p]   <= sq4[p] * HASH_MUL + HASH_ADD;
      n5[p]   <= n4[p];
      lat6[p] <= LAT_ONE - ((n5[p] * t5[p] + HASH_OFS) & HASH_MASK);
    end
  end

  // Stages 7 and 8: 3x3 smoothing around each of the four cell corners.
  for (genvar c = 0; c < 4; c++) begin : g_corner
    localparam int GX = (c % 2) + 1;
    localparam int GY = (c / 2) + 1;
    always_ff @(posedge clk) begin
      csum7[c] <= 34'(lat6[(GY-1)*4 + GX-1]) + 34'(lat6[(GY-1)*4 + GX+1])
                + 34'(lat6[(GY+1)*4 + GX-1]) + 34'(lat6[(GY+1)*4 + GX+1]);
      ssum7[c] <= 34'(lat6[GY*4 + GX-1]) + 34'(lat6[GY*4 + GX+1])
                + 34'(lat6[(GY-1)*4 + GX]) + 34'(lat6[(GY+1)*4 + GX]);
      ctr7[c]  <= lat6[GY*4 + GX];
      sm8[c]   <= 32'((36'(csum7[c]) + (36'(ssum7[c]) <<< 1)
                     + (36'(ctr7[c]) <<< 2) + RND4) >>> 4);
    end
  end

  assign wxc = $signed({1'b0, wx_d[6]});
  assign wxi = W_ONE - wxc;
  assign wyc = $signed({1'b0, wy_d[8]});
  assign wyi = W_ONE - wyc;

  // Stages 9 to 13: blend along x, then along y, then round to Q.20.
  always_ff @(posedge clk) begin
    pa9[0]  <= sm8[0] * wxi;
    pa9[1]  <= sm8[1] * wxc;
    pa9[2]  <= sm8[2] * wxi;
    pa9[3]  <= sm8[3] * wxc;
    tb10[0] <= 32'((pa9[0] + pa9[1] + RND16) >>> 16);
    tb10[1] <= 32'((pa9[2] + pa9[3] + RND16) >>> 16);
    pq11[0] <= tb10[0] * wyi;
    pq11[1] <= tb10[1] * wyc;
    o12     <= 32'((pq11[0] + pq11[1] + RND16) >>> 16);
    v       <= V_W'((o12 + RND10) >>> 10);
  end

endmodule

### rtl/value_noise_2d_octaves.sv
// Top level of the fractal 2D value noise pipeline.
// done follows each accepted start through a shift register of valid bits.
// Throughput: one coordinate per clock outside reset; all octaves run in parallel lanes.
// The octave lanes (13 stages) and the weighting and summing stages set the latency.
// Reset clears the pipeline valid bits and sets persistence to 0.5 and two octaves.
// A persistence write settles the octave amplitudes one octave per cycle.
`timescale 1ns / 1ps

`include "value_noise_2d_octaves_defines.svh"

module value_noise_2d_octaves #(
  parameter int MAX_OCTAVES    = 8,
  parameter int FRAC_BITS      = 12,
  parameter int COS_TABLE_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  vno_pkg::coord_t     x_coord,
  input  vno_pkg::coord_t     y_coord,
  input  logic                cfg_we,
  input  vno_pkg::cfg_idx_t   cfg_index,
  input  vno_pkg::cfg_data_t  cfg_data,
  output logic                done,
  output vno_pkg::noise_t     noise_value
);
  import vno_pkg::*;

  localparam int TREE_LVLS = $clog2(MAX_OCTAVES);
  localparam int TREE_NP   = 1 << TREE_LVLS;
  localparam int SUM_W     = TERM_W + TREE_LVLS;
  localparam int LAT       = 19 + TREE_LVLS;

  localparam logic signed [AMP_W+PERS_W-1:0] AMP_RND  = 58'sd4096;
  localparam logic signed [63:0]             PROD_RND = 64'sd65536;
  localparam logic signed [SUM_W-1:0]        SAT_HI   = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0]        SAT_LO   = SUM_W'(-64'sd2147483648);

  logic     accept;
  logic [LAT-1:0] vld;
  coord_t   x_q, y_q;
  pers_t    persistence;
  octn_t    octave_count;

  amp_t     amp [MAX_OCTAVES];
  amp_t     amp_next [MAX_OCTAVES];

  oct_val_t v_lane [MAX_OCTAVES];
  oct_val_t vd [MAX_OCTAVES];
  logic [MAX_OCTAVES-1:0] en1, en2, en3;
  logic signed [2*V_W-1:0]   plo [MAX_OCTAVES];
  logic signed [2*V_W-2:0]   phi [MAX_OCTAVES];
  logic signed [63:0]        prod3 [MAX_OCTAVES];
  logic signed [TERM_W-1:0]  term [MAX_OCTAVES];
  logic signed [SUM_W-1:0]   t0 [TREE_NP];
  logic signed [SUM_W-1:0]   total;
  logic                      terms_zero;

  assign busy   = rst;
  assign accept = start & ~busy;
  assign done   = vld[LAT-1];

  // Input capture and the valid bits that follow each transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
    if (accept) begin
      x_q <= x_coord;
      y_q <= y_coord;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      persistence  <= PERS_RESET;
      octave_count <= OCTN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PERSISTENCE:  persistence  <= pers_t'(cfg_data);
        REG_OCTAVE_COUNT: octave_count <= cfg_data[OCTN_W-1:0];
      endcase
    end
  end

  // Amplitude chain: each octave follows the one below it in the next cycle.
  always_comb begin
    logic signed [AMP_W+PERS_W-1:0]  prod;
    logic signed [AMP_W+PERS_W-14:0] rnd;
    prod = '0;
    rnd  = '0;
    amp_next[0] = AMP_ONE;
    for (int i = 1; i < MAX_OCTAVES; i++) begin
      prod = (AMP_W+PERS_W)'(amp[i-1]) * (AMP_W+PERS_W)'(persistence);
      rnd  = (AMP_W+PERS_W-13)'((prod + AMP_RND) >>> 13);
      if (rnd > AMP_LIMIT) begin
        amp_next[i] = AMP_LIMIT;
      end else if (rnd < -AMP_LIMIT) begin
        amp_next[i] = -AMP_LIMIT;
      end else begin
        amp_next[i] = AMP_W'(rnd);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_OCTAVES; i++) amp[i] <= amp_reset(i);
    end else begin
      for (int i = 0; i < MAX_OCTAVES; i++) amp[i] <= amp_next[i];
    end
  end

  // One noise lane per octave.
  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_lane
    vno_octave #(
      .OCT            (g),
      .FRAC_BITS      (FRAC_BITS),
      .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_octave (
      .clk     (clk),
      .x_coord (x_q),
      .y_coord (y_q),
      .v       (v_lane[g])
    );
  end

  // Octave enables; these clear at reset so the term stage starts at zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      en1 <= '0;
      en2 <= '0;
      en3 <= '0;
    end else begin
      for (int i = 0; i < MAX_OCTAVES; i++) en1[i] <= (OCTN_W'(i) < octave_count);
      en2 <= en1;
      en3 <= en2;
    end
  end

  // Weighting: the amplitude product is split into two partial products.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      vd[i]    <= v_lane[i];
      plo[i]   <= vd[i] * $signed({1'b0, amp[i][AMP_LO_W-1:0]});
      phi[i]   <= vd[i] * $signed(amp[i][AMP_W-1:AMP_LO_W]);
      prod3[i] <= (64'(phi[i]) <<< AMP_LO_W) + 64'(plo[i]);
      term[i]  <= en3[i] ? TERM_W'((prod3[i] + PROD_RND) >>> 17) : '0;
    end
  end

  always_comb begin
    terms_zero = 1'b1;
    for (int j = 0; j < TREE_NP; j++) t0[j] = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      t0[i] = SUM_W'(term[i]);
      if (term[i] != '0) terms_zero = 1'b0;
    end
  end

  // Adder tree over the octave terms, registered per level; one octave passes straight through.
  if (TREE_LVLS == 0) begin : g_flat
    assign total = t0[0];
  end else begin : g_tree
    logic signed [SUM_W-1:0] tr [TREE_LVLS][TREE_NP];
    always_ff @(posedge clk) begin
      for (int j = 0; j < TREE_NP / 2; j++) tr[0][j] <= t0[2*j] + t0[2*j+1];
      for (int l = 1; l < TREE_LVLS; l++) begin
        for (int j = 0; j < (TREE_NP >> (l + 1)); j++) begin
          tr[l][j] <= tr[l-1][2*j] + tr[l-1][2*j+1];
        end
      end
    end
    assign total = tr[TREE_LVLS-1][0];
  end

  // Saturate to signed Q16.16.
  always_ff @(posedge clk) begin
    if (total > SAT_HI) begin
      noise_value <= NOISE_W'(SAT_HI);
    end else if (total < SAT_LO) begin
      noise_value <= NOISE_W'(SAT_LO);
    end else begin
      noise_value <= NOISE_W'(total);
    end
  end

  // Every result belongs to an earlier accepted transaction.
  `VNO_ASSERT(a_done_has_start, done, $past(accept, LAT))
  // Octaves that are switched off contribute nothing to the sum.
  `VNO_ASSERT_NEXT(a_lanes_off, en3 == '0, terms_zero)
  // The top amplitude stays inside its clamp.
  `VNO_ASSERT(a_amp_clamped, 1'b1,
    amp[MAX_OCTAVES-1] <= AMP_LIMIT && amp[MAX_OCTAVES-1] >= -AMP_LIMIT)

endmodule

### verif/tb.sv
// Self-checking testbench for the fractal 2D value noise pipeline.
`timescale 1ns / 1ps

module tb;
  import vno_pkg::*;

  localparam int LATENCY_WAIT = 48;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    coord_t x;
    coord_t y;
  } coord_pair_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  coord_t     x_coord = '0;
  coord_t     y_coord = '0;
  logic       cfg_we = 1'b0;
  cfg_idx_t   cfg_index = REG_PERSISTENCE;
  cfg_data_t  cfg_data = '0;
  logic       done;
  noise_t     noise_value;

  // Predictor copy of the two registers.
  pers_t      pers_shadow = PERS_RESET;
  octn_t      octn_shadow = OCTN_RESET;

  coord_pair_t coord_queue[$];
  noise_t      noise_expected[$];
  int          send_idle_pct = 16;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  value_noise_2d_octaves dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_coord(x_coord), .y_coord(y_coord),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .noise_value(noise_value)
  );

  always #5 clk = ~clk;

  // Hash of one integer lattice point, signed Q2.30.
  function automatic longint lattice_hash(bit [31:0] ix, bit [31:0] iy);
    bit [31:0] n, m;
    n = ix + iy * 32'd57;
    n = (n << 13) ^ n;
    m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fff_ffff;
    return 64'sd1073741824 - longint'(m);
  endfunction

  function automatic longint round_down_shift(longint v, int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  // Lattice value smoothed over its 3x3 neighborhood.
  function automatic longint smoothed_point(bit [31:0] x, bit [31:0] y);
    longint corners, sides;
    corners = lattice_hash(x - 1, y - 1) + lattice_hash(x + 1, y - 1)
            + lattice_hash(x - 1, y + 1) + lattice_hash(x + 1, y + 1);
    sides = lattice_hash(x - 1, y) + lattice_hash(x + 1, y)
          + lattice_hash(x, y - 1) + lattice_hash(x, y + 1);
    return round_down_shift(corners + 2 * sides + 4 * lattice_hash(x, y), 4);
  endfunction

  // sin^2 by the truncated Horner series, for the lower half of the table.
  function automatic longint unsigned sine_sq_q16(longint unsigned k);
    longint unsigned one, v, v2, t3, t2, t1, s;
    one = 64'd1 << 30;
    v  = (64'd3373259426 * k) >> 9;
    v2 = (v * v) >> 30;
    t3 = one - v2 / 64'd42;
    t2 = one - ((v2 * t3) >> 30) / 64'd20;
    t1 = one - ((v2 * t2) >> 30) / 64'd6;
    s  = (v * t1) >> 30;
    return (s * s + (64'd1 << 43)) >> 44;
  endfunction

  function automatic longint blend_weight(longint unsigned frac);
    longint unsigned k;
    k = (frac >> 4) & 64'd255;
    if (2 * k > 256) begin
      return 65536 - longint'(sine_sq_q16(256 - k));
    end
    return longint'(sine_sq_q16(k));
  endfunction

  function automatic longint cos_blend(longint a, longint b, longint w);
    return round_down_shift(a * (65536 - w) + b * w, 16);
  endfunction

  // One octave of noise at scale 2^i, signed Q2.30.
  function automatic longint octave_noise(longint unsigned x, longint unsigned y, int i);
    longint unsigned sx, sy;
    bit [31:0] ix, iy;
    longint wx, wy, top_row, bot_row;
    sx = x << i;
    sy = y << i;
    ix = sx[43:12];
    iy = sy[43:12];
    wx = blend_weight(sx & 64'hfff);
    wy = blend_weight(sy & 64'hfff);
    top_row = cos_blend(smoothed_point(ix, iy), smoothed_point(ix + 1, iy), wx);
    bot_row = cos_blend(smoothed_point(ix, iy + 1), smoothed_point(ix + 1, iy + 1), wx);
    return cos_blend(top_row, bot_row, wy);
  endfunction

  // Weighted octave sum, saturated to Q16.16.
  function automatic noise_t fractal_noise(coord_t x, coord_t y);
    longint amp, total, v;
    int n;
    amp = 8192;
    total = 0;
    n = (octn_shadow > 8) ? 8 : int'(octn_shadow);
    for (int i = 0; i < n; i++) begin
      v = round_down_shift(octave_noise(longint'(x), longint'(y), i), 10);
      total += round_down_shift(v * amp, 17);
      amp = round_down_shift(amp * longint'(pers_shadow), 13);
      if (amp > 64'sd1099511627776) amp = 64'sd1099511627776;
      if (amp < -64'sd1099511627776) amp = -64'sd1099511627776;
    end
    if (total > 64'sd2147483647) total = 64'sd2147483647;
    if (total < -64'sd2147483648) total = -64'sd2147483648;
    return noise_t'(total);
  endfunction

  // Driver: predicts on each accepted transaction, then offers the next coordinate.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (start && !busy) begin
        noise_expected.push_back(fractal_noise(x_coord, y_coord));
      end
      if (!(start && busy)) begin
        if (coord_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          coord_pair_t c;
          c = coord_queue.pop_front();
          start <= 1'b1;
          x_coord <= c.x;
          y_coord <= c.y;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (noise_expected.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) $display("unexpected result %0d", noise_value);
      end else begin
        noise_t want;
        want = noise_expected.pop_front();
        if (noise_value !== want) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("noise_value mismatch: expected %0d, got %0d", want, noise_value);
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_coord(coord_t x, coord_t y);
    coord_pair_t c;
    c.x = x;
    c.y = y;
    coord_queue.push_back(c);
  endtask

  // Waits until every queued transaction is accepted and every result is in.
  task automatic drain();
    while (coord_queue.size() != 0 || start || noise_expected.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_PERSISTENCE) pers_shadow = pers_t'(value);
    else octn_shadow = octn_t'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic queue_random(int count);
    coord_t x, y;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(3))
        0: begin
          x = coord_t'($urandom_range(32'hff_ffff));
          y = coord_t'($urandom_range(32'hff_ffff));
        end
        1: begin
          x = coord_t'($urandom_range(32'h3fff));
          y = coord_t'($urandom_range(32'h3fff));
        end
        2: begin
          // Fraction around the mirror point of the weight table.
          x = {12'($urandom), 4'h8, 8'($urandom)};
          y = {12'($urandom), 4'h7 + 4'($urandom_range(2)), 8'($urandom)};
        end
        default: begin
          x = coord_t'(32'hff_ffff - $urandom_range(32'h1fff));
          y = coord_t'($urandom);
        end
      endcase
      queue_coord(x, y);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed coordinates at the reset settings.
    queue_coord(24'h0, 24'h0);
    queue_coord(24'hff_ffff, 24'hff_ffff);
    queue_coord(24'h0, 24'hff_ffff);
    queue_coord(24'hff_ffff, 24'h0);
    queue_coord(24'h000_800, 24'h000_800);
    queue_coord(24'h000_810, 24'h000_7f0);
    queue_coord(24'h001_000, 24'h000_fff);
    queue_coord(24'h800_000, 24'h7ff_fff);
    queue_coord(24'haaa_aaa, 24'h555_555);
    queue_coord(24'h555_555, 24'haaa_aaa);
    queue_random(240);
    drain();

    // Largest octave count with the most positive persistence.
    write_reg(REG_PERSISTENCE, 16'h7fff);
    write_reg(REG_OCTAVE_COUNT, 4'd8);
    queue_coord(24'hff_ffff, 24'hff_ffff);
    queue_coord(24'h0, 24'h0);
    queue_random(240);
    drain();

    // Most negative persistence, and a count above the maximum.
    send_idle_pct = 85;
    write_reg(REG_PERSISTENCE, 16'h8000);
    write_reg(REG_OCTAVE_COUNT, 4'd15);
    queue_coord(24'hff_ffff, 24'h0);
    queue_random(200);
    drain();

    // Zero octaves always gives zero.
    write_reg(REG_PERSISTENCE, 16'h0000);
    write_reg(REG_OCTAVE_COUNT, 4'd0);
    queue_coord(24'hff_ffff, 24'hff_ffff);
    queue_random(60);
    drain();

    send_idle_pct = 0;
    write_reg(REG_PERSISTENCE, 16'h2000);
    write_reg(REG_OCTAVE_COUNT, 4'd9);
    queue_random(250);
    drain();

    write_reg(REG_PERSISTENCE, 16'(-5000));
    write_reg(REG_OCTAVE_COUNT, 4'd1);
    queue_random(200);
    drain();

    for (int r = 0; r < 3; r++) begin
      send_idle_pct = (r == 1) ? 16 : 0;
      write_reg(REG_PERSISTENCE, 16'($urandom));
      write_reg(REG_OCTAVE_COUNT, 4'($urandom_range(1, 8)));
      queue_random(100);
      drain();
    end

    if (mismatch_count == 0 && noise_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
